/* rtl/ddmc_pkg.sv */
`default_nettype none
package ddmc_pkg;

  // door phases
  localparam logic [1:0] PH_CLOSED  = 2'd0;
  localparam logic [1:0] PH_OPENING = 2'd1;
  localparam logic [1:0] PH_OPENED  = 2'd2;
  localparam logic [1:0] PH_CLOSING = 2'd3;

  // motor drive codes
  localparam logic [1:0] MOT_OFF = 2'd0;
  localparam logic [1:0] MOT_FWD = 2'd1;
  localparam logic [1:0] MOT_REV = 2'd2;

  // commands
  localparam logic [1:0] ACT_STOP  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TICKS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 8'd1;

  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned TRAVEL_REG_W = 16;
  localparam int unsigned DEB_REG_W    = 8;
  localparam logic [TRAVEL_REG_W-1:0] TRAVEL_TICKS_RST = 16'd5000;
  localparam logic [DEB_REG_W-1:0]    DEB_TICKS_RST    = 8'd50;

  // button slots
  localparam int unsigned KEY_OPEN  = 0;
  localparam int unsigned KEY_CLOSE = 1;
  localparam int unsigned KEY_STOP  = 2;
  localparam int unsigned NUM_BTN   = 3;

  // result fields, door_phase in the lowest bits
  typedef struct packed {
    logic [1:0] active_command;
    logic       phase_changed;
    logic [1:0] motor_drive;
    logic [1:0] door_phase;
  } result_t;

endpackage
`default_nettype wire

/* rtl/debounced_door_motor_controller.sv */
// debounced door motor controller
//
// in_* carries one time tick per request: three raw active-low button
// levels (open, close, stop). Each accepted tick debounces the buttons,
// updates the stored command and steps the door machine and travel timer.
// out_* returns exactly one result per tick: door phase, motor drive,
// a phase-changed flag and the stored command.
// cfg_* writes travel_ticks (index 0) and debounce_ticks (index 1); it is
// always ready and should only be used while the block is idle. Writes to
// other indexes are dropped.
// A tick's result goes to the result register, or to the skid register
// in a stall. One tick can be accepted every clock while in_tready is
// high, each update one pass of short logic into the state registers.
// A two-deep output (result register plus skid register) lets the block
// take one more tick while the receiver stalls; in_tready drops only when
// both hold results.
// Synchronous reset: door closed, motor off, command stop, buttons
// released and already stable, timer idle, registers at 5000 and 50.
`default_nettype none
module debounced_door_motor_controller
  import ddmc_pkg::*;
#(
  parameter int unsigned TRAVEL_COUNT_WIDTH   = 16,
  parameter int unsigned DEBOUNCE_COUNT_WIDTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tdata: [0] open_level_n, [1] close_level_n, [2] stop_level_n
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,
  // tdata: [1:0] door_phase, [3:2] motor_drive, [4] phase_changed,
  //        [6:5] active_command
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned TW = TRAVEL_COUNT_WIDTH;
  localparam int unsigned DW = DEBOUNCE_COUNT_WIDTH;
  localparam logic [TW-1:0] TRAVEL_MAX = {TW{1'b1}};
  localparam logic [DW-1:0] DEB_MAX    = {DW{1'b1}};
  localparam logic [32:0]   TRAVEL_MAX_W = 33'({TW{1'b1}});
  localparam logic [32:0]   DEB_MAX_W    = 33'({DW{1'b1}});

  logic [TRAVEL_REG_W-1:0] travel_ticks_r;
  logic [DEB_REG_W-1:0]    debounce_ticks_r;

  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    drive_r, drive_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [TW-1:0] elapsed_r, elapsed_nxt;
  logic          running_r, running_nxt;
  logic          done_r, done_nxt;
  logic [NUM_BTN-1:0] level_r, level_nxt;
  logic [NUM_BTN-1:0] latched_r, latched_nxt;
  logic [DW-1:0] stable_r [NUM_BTN];
  logic [DW-1:0] stable_nxt [NUM_BTN];

  result_t out_r, skid_r, result;
  logic    out_valid_r, skid_valid_r;

  logic [TW-1:0]      travel_limit;
  logic [DW-1:0]      deb_limit;
  logic [NUM_BTN-1:0] lvl;
  logic               in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign lvl       = in_tdata[NUM_BTN-1:0];

  // clip limits to the counter widths
  assign travel_limit = (33'(travel_ticks_r) > TRAVEL_MAX_W) ? TRAVEL_MAX
                                                             : TW'(travel_ticks_r);
  assign deb_limit = (33'(debounce_ticks_r) > DEB_MAX_W) ? DEB_MAX
                                                         : DW'(debounce_ticks_r);

  always_comb begin
    logic start;
    phase_nxt   = phase_r;
    drive_nxt   = drive_r;
    elapsed_nxt = elapsed_r;
    running_nxt = running_r;
    done_nxt    = done_r;
    start       = 1'b0;

    // door machine acts on last tick's command
    unique case (phase_r)
      PH_CLOSED: begin
        if (cmd_r == ACT_OPEN) begin
          start = 1'b1; drive_nxt = MOT_FWD; phase_nxt = PH_OPENING;
        end
      end
      PH_OPENING: begin
        if (cmd_r == ACT_CLOSE) begin
          start = 1'b1; drive_nxt = MOT_REV; phase_nxt = PH_CLOSING;
        end else if (done_r) begin
          drive_nxt = MOT_OFF; phase_nxt = PH_OPENED; done_nxt = 1'b0;
        end
      end
      PH_OPENED: begin
        if (cmd_r == ACT_CLOSE) begin
          start = 1'b1; drive_nxt = MOT_REV; phase_nxt = PH_CLOSING;
        end
      end
      PH_CLOSING: begin
        if (cmd_r == ACT_OPEN) begin
          start = 1'b1; drive_nxt = MOT_FWD; phase_nxt = PH_OPENING;
        end else if (done_r) begin
          drive_nxt = MOT_OFF; phase_nxt = PH_CLOSED; done_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (start) begin
      elapsed_nxt = '0;
      running_nxt = 1'b1;
      done_nxt    = 1'b0;
    end

    // travel timer
    if (running_nxt) begin
      if (elapsed_nxt != TRAVEL_MAX) begin
        elapsed_nxt = elapsed_nxt + 1'b1;
      end
      if (elapsed_nxt >= travel_limit) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  // debouncers
  always_comb begin
    level_nxt   = level_r;
    latched_nxt = latched_r;
    for (int i = 0; i < NUM_BTN; i++) begin
      stable_nxt[i] = stable_r[i];
      if (lvl[i] != level_r[i]) begin
        level_nxt[i]  = lvl[i];
        stable_nxt[i] = '0;
      end else begin
        if (stable_r[i] != DEB_MAX) begin
          stable_nxt[i] = stable_r[i] + 1'b1;
        end
        if (stable_nxt[i] >= deb_limit) begin
          latched_nxt[i] = !lvl[i];
        end
      end
    end
    priority if (latched_nxt[KEY_STOP]) begin
      cmd_nxt = ACT_STOP;
    end else if (latched_nxt[KEY_OPEN]) begin
      cmd_nxt = ACT_OPEN;
    end else if (latched_nxt[KEY_CLOSE]) begin
      cmd_nxt = ACT_CLOSE;
    end else begin
      cmd_nxt = cmd_r;
    end
  end

  always_comb begin
    result.door_phase     = phase_nxt;
    result.motor_drive    = drive_nxt;
    result.phase_changed  = (phase_nxt != phase_r);
    result.active_command = cmd_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_ticks_r   <= TRAVEL_TICKS_RST;
      debounce_ticks_r <= DEB_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TRAVEL_TICKS) begin
        travel_ticks_r <= cfg_data[TRAVEL_REG_W-1:0];
      end else if (cfg_index == REG_DEBOUNCE_TICKS) begin
        debounce_ticks_r <= cfg_data[DEB_REG_W-1:0];
      end
    end
  end

  // tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CLOSED;
      drive_r   <= MOT_OFF;
      cmd_r     <= ACT_STOP;
      elapsed_r <= '0;
      running_r <= 1'b0;
      done_r    <= 1'b0;
      level_r   <= '1;
      latched_r <= '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        stable_r[i] <= DEB_MAX;
      end
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      drive_r   <= drive_nxt;
      cmd_r     <= cmd_nxt;
      elapsed_r <= elapsed_nxt;
      running_r <= running_nxt;
      done_r    <= done_nxt;
      level_r   <= level_nxt;
      latched_r <= latched_nxt;
      for (int i = 0; i < NUM_BTN; i++) begin
        stable_r[i] <= stable_nxt[i];
      end
    end
  end

  // result register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : result;
    end else if (in_fire) begin
      skid_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_motor_off_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CLOSED || phase_r == PH_OPENED) |-> (drive_r == MOT_OFF))
    else $error("motor driven while door at rest");

  a_timer_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(running_r && done_r))
    else $error("travel timer running and done together");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && in_fire) |=> skid_valid_r)
    else $error("request accepted during stall was not kept");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ddmc_pkg::*;

  // raw button levels, bit 0 open, bit 1 close, bit 2 stop, active low
  localparam logic [2:0] LV_IDLE  = 3'b111;
  localparam logic [2:0] LV_OPEN  = 3'b110;
  localparam logic [2:0] LV_CLOSE = 3'b101;
  localparam logic [2:0] LV_STOP  = 3'b011;
  localparam logic [2:0] LV_ALL   = 3'b000;

  // an index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hFF;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = {5'b0, LV_IDLE};
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  debounced_door_motor_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // door model state and its copy of the registers
  logic [1:0]              door_q;
  logic [1:0]              drive_q;
  logic [1:0]              cmd_q;
  logic [TRAVEL_REG_W-1:0] travel_count;
  logic                    travel_on;
  logic                    travel_expired;
  logic [NUM_BTN-1:0]      btn_level;
  logic [DEB_REG_W-1:0]    btn_count [NUM_BTN];
  logic [NUM_BTN-1:0]      btn_held;
  logic [TRAVEL_REG_W-1:0] travel_limit;
  logic [DEB_REG_W-1:0]    debounce_limit;

  logic [2:0] tick_queue [$];
  result_t    door_results_due [$];
  int         ticks_queued = 0;
  int         results_seen = 0;
  int         error_count = 0;

  logic in_took = 1'b0;
  logic cfg_took = 1'b0;

  // sender burst state
  int burst_left = 1;
  int gap_left = 0;

  // receiver stall pattern state
  rx_mode_t rx_mode = RX_STEADY;
  int       rx_mode_left = 0;
  int       rx_hold = 0;
  logic     rx_level = 1'b1;
  int       rx_cycle = 0;

  result_t got_result;
  result_t want_result;

  task automatic report_mismatch(input string what);
    $display("mismatch on result %0d: %s", results_seen, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  function automatic void start_travel();
    travel_count = '0;
    travel_on = 1'b1;
    travel_expired = 1'b0;
  endfunction

  function automatic void reset_door_model();
    door_q = PH_CLOSED;
    drive_q = MOT_OFF;
    cmd_q = ACT_STOP;
    travel_count = '0;
    travel_on = 1'b0;
    travel_expired = 1'b0;
    btn_level = '1;
    btn_held = '0;
    for (int i = 0; i < NUM_BTN; i++) btn_count[i] = '1;
    travel_limit = TRAVEL_TICKS_RST;
    debounce_limit = DEB_TICKS_RST;
  endfunction

  function automatic result_t predict_door_tick(input logic [2:0] lv);
    result_t    r;
    logic [1:0] prev_door;
    prev_door = door_q;
    // door machine acts on the command stored on the previous tick
    case (door_q)
      PH_CLOSED: begin
        if (cmd_q == ACT_OPEN) begin
          start_travel();
          drive_q = MOT_FWD;
          door_q = PH_OPENING;
        end
      end
      PH_OPENING: begin
        if (cmd_q == ACT_CLOSE) begin
          start_travel();
          drive_q = MOT_REV;
          door_q = PH_CLOSING;
        end else if (travel_expired) begin
          drive_q = MOT_OFF;
          door_q = PH_OPENED;
          travel_expired = 1'b0;
        end
      end
      PH_OPENED: begin
        if (cmd_q == ACT_CLOSE) begin
          start_travel();
          drive_q = MOT_REV;
          door_q = PH_CLOSING;
        end
      end
      default: begin
        if (cmd_q == ACT_OPEN) begin
          start_travel();
          drive_q = MOT_FWD;
          door_q = PH_OPENING;
        end else if (travel_expired) begin
          drive_q = MOT_OFF;
          door_q = PH_CLOSED;
          travel_expired = 1'b0;
        end
      end
    endcase
    if (travel_on) begin
      if (travel_count != '1) travel_count++;
      if (travel_count >= travel_limit) begin
        travel_on = 1'b0;
        travel_expired = 1'b1;
      end
    end
    for (int i = 0; i < NUM_BTN; i++) begin
      if (lv[i] != btn_level[i]) begin
        btn_level[i] = lv[i];
        btn_count[i] = '0;
      end else begin
        if (btn_count[i] != '1) btn_count[i]++;
        if (btn_count[i] >= debounce_limit) btn_held[i] = (lv[i] == 1'b0);
      end
    end
    if (btn_held[KEY_STOP]) cmd_q = ACT_STOP;
    else if (btn_held[KEY_OPEN]) cmd_q = ACT_OPEN;
    else if (btn_held[KEY_CLOSE]) cmd_q = ACT_CLOSE;
    r.door_phase = door_q;
    r.motor_drive = drive_q;
    r.phase_changed = (door_q != prev_door);
    r.active_command = cmd_q;
    return r;
  endfunction

  // monitor: register writes, accepted ticks and returned results
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_door_model();
      in_took <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TRAVEL_TICKS) travel_limit = cfg_data;
        else if (cfg_index == REG_DEBOUNCE_TICKS) debounce_limit = cfg_data[DEB_REG_W-1:0];
      end
      if (in_tvalid && in_tready)
        door_results_due.push_back(predict_door_tick(in_tdata[2:0]));
      if (out_tvalid && out_tready) begin
        got_result = result_t'(out_tdata[6:0]);
        if (door_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          want_result = door_results_due.pop_front();
          check_field("door_phase", got_result.door_phase, want_result.door_phase);
          check_field("motor_drive", got_result.motor_drive, want_result.motor_drive);
          check_field("phase_changed", got_result.phase_changed,
                      want_result.phase_changed);
          check_field("active_command", got_result.active_command,
                      want_result.active_command);
        end
        results_seen++;
      end
      in_took <= in_tvalid && in_tready;
      cfg_took <= cfg_valid && cfg_ready;
    end
  end

  // sender: bursts of requests with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        in_tdata <= {5'b0, tick_queue.pop_front()};
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches among four randomly chosen modes
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(32, 400);
      end else begin
        rx_mode_left--;
      end
      rx_cycle++;
      case (rx_mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= (rx_cycle % 4 == 0);
        default: begin
          if (rx_hold == 0) begin
            rx_hold = $urandom_range(1, 16);
            rx_level = ~rx_level;
          end else begin
            rx_hold--;
          end
          out_tready <= rx_level;
        end
      endcase
    end
  end

  task automatic push_ticks(input logic [2:0] lv, input int n);
    repeat (n) begin
      tick_queue.push_back(lv);
      ticks_queued++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_queue.size() != 0 || door_results_due.size() != 0 ||
           (in_tvalid && !in_took));
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // mostly debounced presses followed by a release, with bounce and noise
  task automatic random_session(input int n_ticks, input int deb, input int trav);
    int         start;
    logic [2:0] lv;
    start = ticks_queued;
    while (ticks_queued - start < n_ticks) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0, 1:    lv = LV_OPEN;
          2, 3:    lv = LV_CLOSE;
          4:       lv = LV_STOP;
          default: lv = 3'($urandom_range(0, 7));
        endcase
        repeat ($urandom_range(0, 3))
          push_ticks($urandom_range(0, 1) ? lv : LV_IDLE, 1);
        push_ticks(lv, $urandom_range((deb > 1) ? deb - 1 : 1, 2 * deb + 2));
        push_ticks(LV_IDLE, $urandom_range(1, deb + trav + 4));
      end else begin
        repeat ($urandom_range(1, deb + 1)) push_ticks(3'($urandom_range(0, 7)), 1);
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset register values: open press held past the debounce
    push_ticks(LV_IDLE, 3);
    push_ticks(LV_OPEN, 55);
    push_ticks(LV_IDLE, 10);

    // directed part with short debounce and travel
    set_reg(REG_TRAVEL_TICKS, 16'd3);
    set_reg(REG_DEBOUNCE_TICKS, 16'd1);
    push_ticks(LV_CLOSE, 2);
    push_ticks(LV_IDLE, 5);
    push_ticks(LV_OPEN, 2);
    push_ticks(LV_IDLE, 1);
    // a further open press, then a close press
    push_ticks(LV_OPEN, 2);
    push_ticks(LV_CLOSE, 2);
    // stop does not halt the motor, stop wins over everything
    push_ticks(LV_STOP, 2);
    push_ticks(LV_ALL, 2);
    push_ticks(LV_IDLE, 5);
    push_ticks(3'b100, 2);

    // shortest travel and debounce
    set_reg(REG_TRAVEL_TICKS, 16'd1);
    set_reg(REG_DEBOUNCE_TICKS, 16'd1);
    random_session(120, 1, 1);

    set_reg(REG_TRAVEL_TICKS, 16'($urandom_range(4, 30)));
    set_reg(REG_DEBOUNCE_TICKS, 16'($urandom_range(2, 6)));
    random_session(150, 6, 30);

    set_reg(REG_TRAVEL_TICKS, 16'($urandom_range(2, 12)));
    set_reg(REG_DEBOUNCE_TICKS, 16'($urandom_range(1, 3)));
    random_session(120, 3, 12);

    // longest debounce, upper data bits must be dropped
    set_reg(REG_TRAVEL_TICKS, 16'($urandom_range(10, 30)));
    set_reg(REG_DEBOUNCE_TICKS, {8'($urandom_range(1, 255)), 8'd255});
    push_ticks(LV_CLOSE, 258);
    push_ticks(LV_IDLE, 20);

    // write to an unmapped index changes nothing
    set_reg(REG_SPARE, 16'($urandom));
    // zero limits: timer expires after one tick, every steady tick counts
    set_reg(REG_TRAVEL_TICKS, 16'd0);
    set_reg(REG_DEBOUNCE_TICKS, 16'd0);
    random_session(80, 1, 1);

    wait_idle();
    repeat (4) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
